>>> hdl/gzl_pkg.sv
// Shared types and constants of the zone grid block.
// Widths, reset values, register indexes, operation codes and unit request/response structs.
// No dependencies.
package gzl_pkg;

  localparam int COORD_W    = 16;
  localparam int CELL_W     = 15;
  localparam int IDX_W      = 16;
  localparam int RAD_W      = 2;
  localparam int DIV_W      = 17;
  localparam int DIVR_W     = 16;
  localparam int MUL_W      = 16;
  localparam int ZC_W       = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_RADIUS = 3;

  localparam logic [ZC_W-1:0] MAX_ZONES = 17'd65536;

  localparam logic signed [COORD_W-1:0] RST_MAP_MIN_X = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_MAP_MIN_Y = 16'sd0;
  localparam logic signed [COORD_W-1:0] RST_MAP_MAX_X = 16'sd1024;
  localparam logic signed [COORD_W-1:0] RST_MAP_MAX_Y = 16'sd1024;
  localparam logic [CELL_W-1:0]         RST_CELL_SIZE = 15'd64;
  localparam logic [IDX_W-1:0]          RST_COLS      = 16'd16;
  localparam logic [IDX_W-1:0]          RST_ROWS      = 16'd16;
  localparam logic [ZC_W-1:0]           RST_ZONES     = 17'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_MIN_X = 3'd0,
    CFG_MAP_MIN_Y = 3'd1,
    CFG_MAP_MAX_X = 3'd2,
    CFG_MAP_MAX_Y = 3'd3,
    CFG_CELL_SIZE = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_LOCATE = 1'b0,
    OP_NEIGH  = 1'b1
  } op_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DIV_W-1:0]  quotient;
    logic [DIVR_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               busy;
    logic [2*MUL_W-1:0] product;
  } mul_rsp_t;

endpackage

>>> hdl/gzl_in_if.sv
// Query channel: valid/ready handshake carrying one query item.
// Depends on gzl_pkg for field widths.
interface gzl_in_if import gzl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_z;
  logic [IDX_W-1:0]          zone_index;
  logic [RAD_W-1:0]          view_radius;

  modport source (output valid, operation, pos_x, pos_z, zone_index, view_radius,
                  input ready);
  modport sink   (input valid, operation, pos_x, pos_z, zone_index, view_radius,
                  output ready);
endinterface

>>> hdl/gzl_out_if.sv
// Result channel: valid/ready handshake carrying one result item.
// Depends on gzl_pkg for field widths.
interface gzl_out_if import gzl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             valid_res;
  logic             last;

  modport source (output valid, result_index, valid_res, last, input ready);
  modport sink   (input valid, result_index, valid_res, last, output ready);
endinterface

>>> hdl/grid_zone_locate_and_neighbourhood_top.sv
// Zone grid: locate a position's zone, or list a zone's neighbourhood.
// Locate: two divides (x and y offset by cell size), then a multiply (row by cols) plus the column.
// Neighbourhood: lists the in-grid cells within radius r, scanning one cell per cycle
// unless the output stalls; an invalid zone or an empty grid gives its result without a divide.
// One item at a time, the next taken once the last result is presented; a config write to a
// known index holds off items while the grid is derived again. Sync reset loads the 16 x 16 grid.
module grid_zone_locate_and_neighbourhood_top import gzl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  gzl_in_if.sink                query,
  gzl_out_if.source             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CFG_COLS, S_CFG_ROWS, S_CFG_ZONES,
    S_LOC_X, S_LOC_Y, S_LOC_MUL, S_LOC_FIN, S_EMIT1,
    S_NB_DIV, S_NB_BACK, S_NB_SCAN, S_NB_FLUSH
  } state_t;

  state_t state;

  logic signed [COORD_W-1:0] map_min_x, map_min_y, map_max_x, map_max_y;
  logic [CELL_W-1:0]         cell_size;
  logic [IDX_W-1:0]          cols, rows;
  logic [ZC_W-1:0]           zone_count;
  logic                      dirty;
  logic                      cfg_hit;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic [IDX_W-1:0]        y_off, zx, zi, cx, cy, pend_idx, res_idx;
  logic [RAD_W-1:0]        rad, back_cnt;
  logic signed [19:0]      row_base;
  logic signed [2:0]       dx, dy;
  logic                    pend_full, res_valid;
  logic                    out_valid, out_vres, out_last;
  logic [IDX_W-1:0]        out_idx;

  logic [CELL_W-1:0]         cs_eff;
  logic signed [COORD_W:0]   span_x, span_y;
  logic [DIV_W-1:0]          dvd_x, dvd_y;
  logic signed [COORD_W-1:0] xc, yc;
  logic [IDX_W-1:0]          x_off_in, y_off_in;
  logic [RAD_W-1:0]          rad_in;
  logic [31:0]               loc_sum;
  logic signed [2:0]         r_s;
  logic signed [17:0]        nx, ny;
  logic signed [19:0]        idx20;
  logic                      cell_ok, out_free, scan_end, scan_stall;

  gzl_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  gzl_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));

  always_comb begin
    case (cfg_idx_t'(cfg_index))
      CFG_MAP_MIN_X, CFG_MAP_MIN_Y, CFG_MAP_MAX_X, CFG_MAP_MAX_Y, CFG_CELL_SIZE: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_min_x <= RST_MAP_MIN_X;
      map_min_y <= RST_MAP_MIN_Y;
      map_max_x <= RST_MAP_MAX_X;
      map_max_y <= RST_MAP_MAX_Y;
      cell_size <= RST_CELL_SIZE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAP_MIN_X: map_min_x <= cfg_data;
        CFG_MAP_MIN_Y: map_min_y <= cfg_data;
        CFG_MAP_MAX_X: map_max_x <= cfg_data;
        CFG_MAP_MAX_Y: map_max_y <= cfg_data;
        CFG_CELL_SIZE: cell_size <= cfg_data[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cs_eff = (cell_size == '0) ? CELL_W'(1) : cell_size;
  assign span_x = {map_max_x[COORD_W-1], map_max_x} - {map_min_x[COORD_W-1], map_min_x};
  assign span_y = {map_max_y[COORD_W-1], map_max_y} - {map_min_y[COORD_W-1], map_min_y};
  assign dvd_x  = (span_x > 17'sd0) ? ($unsigned(span_x) + {2'b00, cs_eff} - 17'd1) : '0;
  assign dvd_y  = (span_y > 17'sd0) ? ($unsigned(span_y) + {2'b00, cs_eff} - 17'd1) : '0;

  assign xc = (query.pos_x < map_min_x) ? map_min_x :
              ((query.pos_x >= map_max_x) ? map_max_x - 16'sd1 : query.pos_x);
  assign yc = (query.pos_z < map_min_y) ? map_min_y :
              ((query.pos_z >= map_max_y) ? map_max_y - 16'sd1 : query.pos_z);
  assign x_off_in = $unsigned(xc - map_min_x);
  assign y_off_in = $unsigned(yc - map_min_y);
  assign rad_in   = (query.view_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                             : query.view_radius;

  assign loc_sum = mul_rsp.product + {16'd0, zx};

  assign r_s      = $signed({1'b0, rad});
  assign nx       = $signed({2'b00, cx}) + $signed({{15{dx[2]}}, dx});
  assign ny       = $signed({2'b00, cy}) + $signed({{15{dy[2]}}, dy});
  assign idx20    = row_base + $signed({{2{nx[17]}}, nx});
  assign cell_ok  = !nx[17] && (nx[16:0] < {1'b0, cols}) &&
                    !ny[17] && (ny[16:0] < {1'b0, rows}) &&
                    !idx20[19] && (idx20[18:0] < {2'b00, zone_count});
  assign out_free   = !out_valid || result.ready;
  assign scan_end   = (dx == r_s) && (dy == r_s);
  assign scan_stall = cell_ok && pend_full && !out_free;

  assign query.ready = (state == S_IDLE) && !dirty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      dirty         <= 1'b0;
      out_valid     <= 1'b0;
      pend_full     <= 1'b0;
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      cols          <= RST_COLS;
      rows          <= RST_ROWS;
      zone_count    <= RST_ZONES;
    end else begin
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (dirty) begin
            dirty            <= 1'b0;
            div_req.start    <= 1'b1;
            div_req.dividend <= dvd_x;
            div_req.divisor  <= {1'b0, cs_eff};
            state            <= S_CFG_COLS;
          end else if (query.valid) begin
            if (op_t'(query.operation) == OP_LOCATE) begin
              if (zone_count == '0) begin
                res_idx   <= '0;
                res_valid <= 1'b0;
                state     <= S_EMIT1;
              end else begin
                y_off            <= y_off_in;
                div_req.start    <= 1'b1;
                div_req.dividend <= {1'b0, x_off_in};
                div_req.divisor  <= {1'b0, cs_eff};
                state            <= S_LOC_X;
              end
            end else begin
              zi  <= query.zone_index;
              rad <= rad_in;
              if ({1'b0, query.zone_index} >= zone_count) begin
                res_idx   <= '0;
                res_valid <= 1'b0;
                state     <= S_EMIT1;
              end else begin
                div_req.start    <= 1'b1;
                div_req.dividend <= {1'b0, query.zone_index};
                div_req.divisor  <= cols;
                state            <= S_NB_DIV;
              end
            end
          end
        end
        S_CFG_COLS: begin
          if (div_rsp.done) begin
            cols             <= div_rsp.quotient[IDX_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= dvd_y;
            div_req.divisor  <= {1'b0, cs_eff};
            state            <= S_CFG_ROWS;
          end
        end
        S_CFG_ROWS: begin
          if (div_rsp.done) begin
            rows          <= div_rsp.quotient[IDX_W-1:0];
            mul_req.start <= 1'b1;
            mul_req.a     <= cols;
            mul_req.b     <= div_rsp.quotient[IDX_W-1:0];
            state         <= S_CFG_ZONES;
          end
        end
        S_CFG_ZONES: begin
          if (mul_rsp.done) begin
            zone_count <= (mul_rsp.product > {15'd0, MAX_ZONES}) ? MAX_ZONES
                                                                 : mul_rsp.product[ZC_W-1:0];
            state      <= S_IDLE;
          end
        end
        S_LOC_X: begin
          if (div_rsp.done) begin
            zx               <= div_rsp.quotient[IDX_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= {1'b0, y_off};
            div_req.divisor  <= {1'b0, cs_eff};
            state            <= S_LOC_Y;
          end
        end
        S_LOC_Y: begin
          if (div_rsp.done) begin
            mul_req.start <= 1'b1;
            mul_req.a     <= div_rsp.quotient[IDX_W-1:0];
            mul_req.b     <= cols;
            state         <= S_LOC_MUL;
          end
        end
        S_LOC_MUL: begin
          if (mul_rsp.done) begin
            state <= S_LOC_FIN;
          end
        end
        S_LOC_FIN: begin
          if (loc_sum < {15'd0, zone_count}) begin
            res_idx   <= loc_sum[IDX_W-1:0];
            res_valid <= 1'b1;
          end else begin
            res_idx   <= '0;
            res_valid <= 1'b0;
          end
          state <= S_EMIT1;
        end
        S_EMIT1: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_idx   <= res_idx;
            out_vres  <= res_valid;
            out_last  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_NB_DIV: begin
          if (div_rsp.done) begin
            cx       <= div_rsp.remainder;
            cy       <= div_rsp.quotient[IDX_W-1:0];
            row_base <= $signed({4'd0, zi}) - $signed({4'd0, div_rsp.remainder});
            back_cnt <= rad;
            state    <= S_NB_BACK;
          end
        end
        S_NB_BACK: begin
          if (back_cnt == '0) begin
            dx    <= -r_s;
            dy    <= -r_s;
            state <= S_NB_SCAN;
          end else begin
            row_base <= row_base - $signed({4'd0, cols});
            back_cnt <= back_cnt - 1'b1;
          end
        end
        S_NB_SCAN: begin
          if (!scan_stall) begin
            if (cell_ok) begin
              if (pend_full) begin
                out_valid <= 1'b1;
                out_idx   <= pend_idx;
                out_vres  <= 1'b1;
                out_last  <= 1'b0;
              end
              pend_idx  <= idx20[IDX_W-1:0];
              pend_full <= 1'b1;
            end
            if (scan_end) begin
              state <= S_NB_FLUSH;
            end else if (dx == r_s) begin
              dx       <= -r_s;
              dy       <= dy + 3'sd1;
              row_base <= row_base + $signed({4'd0, cols});
            end else begin
              dx <= dx + 3'sd1;
            end
          end
        end
        S_NB_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_idx   <= pend_idx;
            out_vres  <= 1'b1;
            out_last  <= 1'b1;
            pend_full <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_we && cfg_hit) begin
        dirty <= 1'b1;
      end
    end
  end

  assign result.valid        = out_valid;
  assign result.result_index = out_idx;
  assign result.valid_res    = out_vres;
  assign result.last         = out_last;

`ifndef SYNTHESIS
  a_accept_drops_ready: assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> !query.ready)
    else $error("ready still high after an item was taken");

  a_zone_cap: assert property (@(posedge clk) disable iff (rst)
    zone_count <= MAX_ZONES)
    else $error("zone count above cap");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_full)
    else $error("pending neighbour left behind in idle");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_NB_FLUSH |-> pend_full)
    else $error("flush without a pending neighbour");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");
`endif

endmodule

>>> hdl/gzl_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gzl_pkg for widths and the request/response structs.
module gzl_div import gzl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  q_sh;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] divisor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;

  assign trial = {rem, q_sh[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        q_sh    <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= CNT_W'(DIV_W);
        busy    <= 1'b1;
      end else if (busy) begin
        if (!diff[DIVR_W]) begin
          rem  <= diff[DIVR_W-1:0];
          q_sh <= {q_sh[DIV_W-2:0], 1'b1};
        end else begin
          rem  <= trial[DIVR_W-1:0];
          q_sh <= {q_sh[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.busy      = busy;
  assign rsp.quotient  = q_sh;
  assign rsp.remainder = rem;

endmodule

>>> hdl/gzl_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on gzl_pkg for widths and the request/response structs.
module gzl_mul import gzl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic [2*MUL_W-1:0] p;
  logic [MUL_W-1:0]   a;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [MUL_W:0]     sum;

  assign sum = {1'b0, p[2*MUL_W-1:MUL_W]} + (p[0] ? {1'b0, a} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        p    <= {{MUL_W{1'b0}}, req.b};
        a    <= req.a;
        cnt  <= CNT_W'(MUL_W);
        busy <= 1'b1;
      end else if (busy) begin
        p   <= {sum, p[MUL_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.busy    = busy;
  assign rsp.product = p;

endmodule
